@@ hdl/hrd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrd_pkg
// Shared types and constants for the hysteresis run detector.
// ----------------------------------------------------------------------------
package hrd_pkg;

    localparam int unsigned MAX_SAMPLES   = 65536;
    localparam int unsigned INDEX_CAP_INT =
        ((MAX_SAMPLES - 1) > 65535) ? 65535 : (MAX_SAMPLES - 1);
    localparam logic [15:0] INDEX_CAP     = 16'(INDEX_CAP_INT);

    localparam int unsigned CFG_DATA_W  = 24;
    localparam int unsigned CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HIGH_THRESHOLD    = 2'd0,
        REG_LOW_THRESHOLD     = 2'd1,
        REG_GAP_CLOSE_SAMPLES = 2'd2,
        REG_MIN_RUN_SAMPLES   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [23:0] energy_sample;
        logic        last_sample;
    } in_word_t;

    typedef struct packed {
        logic [15:0] run_start;
        logic [15:0] run_end;
        logic        closed_by_end;
    } out_word_t;

endpackage

@@ hdl/hysteresis_run_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hysteresis_run_detector
// Opens a run at the high threshold, holds it at or above the low threshold,
// closes it after a gap or at stream end, and reports runs that are long enough.
// ----------------------------------------------------------------------------
// One energy word is taken every cycle while the output is not stalled. A word
// is captured in an input register; the threshold compares, gap counter update
// and run length check are then done on it in one pass, and a result word, if
// any, is written to the output register when that register is free or being
// read. Throughput drops below one word per cycle only while out_ready is
// held low and the output register is full. Configuration writes take effect
// at once and must be made while no stream is in flight.
module hysteresis_run_detector (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  hrd_pkg::in_word_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output hrd_pkg::out_word_t                  out_data,
    input  logic                                cfg_we,
    input  logic [hrd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [hrd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import hrd_pkg::*;

    logic [23:0] high_threshold_reg;
    logic [23:0] low_threshold_reg;
    logic [15:0] gap_limit_reg;
    logic [16:0] min_run_reg;

    logic        s1_valid_reg;
    in_word_t    s1_data_reg;
    logic        out_valid_reg;
    out_word_t   out_data_reg;

    logic        run_active_reg;
    logic        run_active_next;
    logic [15:0] open_start_reg;
    logic [15:0] open_start_next;
    logic [16:0] gap_count_reg;
    logic [16:0] gap_count_next;
    logic [15:0] sample_index_reg;
    logic [15:0] sample_index_next;

    logic        advance;
    logic        above_low;
    logic [16:0] gap_inc;
    logic        gap_hit;
    logic [17:0] gap_diff;
    logic [15:0] gap_end;
    logic [15:0] sel_end;
    logic        sel_by_end;
    logic        candidate;
    logic [16:0] run_len;
    logic        emit;
    out_word_t   out_data_next;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_threshold_reg <= '0;
            low_threshold_reg  <= '0;
            gap_limit_reg      <= '0;
            min_run_reg        <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_HIGH_THRESHOLD:    high_threshold_reg <= cfg_data[23:0];
                REG_LOW_THRESHOLD:     low_threshold_reg  <= cfg_data[23:0];
                REG_GAP_CLOSE_SAMPLES: gap_limit_reg      <= cfg_data[15:0];
                REG_MIN_RUN_SAMPLES:   min_run_reg        <= cfg_data[16:0];
                default:               ;
            endcase
        end
    end

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;

    // run tracking for the word in the input register
    always_comb
    begin
        above_low  = s1_data_reg.energy_sample >= low_threshold_reg;
        gap_inc    = gap_count_reg + 17'd1;
        gap_hit    = 1'b0;
        gap_diff   = {2'b00, sample_index_reg} - {1'b0, gap_inc};
        if (gap_diff[17] || (gap_diff[15:0] < open_start_reg))
            gap_end = open_start_reg;
        else
            gap_end = gap_diff[15:0];

        run_active_next = run_active_reg;
        open_start_next = open_start_reg;
        gap_count_next  = gap_count_reg;

        if (!run_active_reg)
        begin
            if (s1_data_reg.energy_sample >= high_threshold_reg)
            begin
                run_active_next = 1'b1;
                open_start_next = sample_index_reg;
                gap_count_next  = '0;
            end
        end
        else if (above_low)
        begin
            gap_count_next = '0;
        end
        else
        begin
            gap_count_next = gap_inc;
            if (gap_inc > {1'b0, gap_limit_reg})
            begin
                gap_hit         = 1'b1;
                run_active_next = 1'b0;
                gap_count_next  = '0;
            end
        end

        // a run still open at end of stream is closed by the end
        if (s1_data_reg.last_sample && run_active_next)
        begin
            sel_end    = sample_index_reg;
            sel_by_end = 1'b1;
            candidate  = 1'b1;
        end
        else
        begin
            sel_end    = gap_end;
            sel_by_end = 1'b0;
            candidate  = gap_hit;
        end

        run_len = {1'b0, sel_end} - {1'b0, open_start_next} + 17'd1;
        emit    = candidate && (run_len >= min_run_reg);

        out_data_next.run_start     = open_start_next;
        out_data_next.run_end       = sel_end;
        out_data_next.closed_by_end = sel_by_end;

        if (s1_data_reg.last_sample)
        begin
            run_active_next   = 1'b0;
            open_start_next   = '0;
            gap_count_next    = '0;
            sample_index_next = '0;
        end
        else if (sample_index_reg < INDEX_CAP)
            sample_index_next = sample_index_reg + 16'd1;
        else
            sample_index_next = sample_index_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            run_active_reg   <= 1'b0;
            open_start_reg   <= '0;
            gap_count_reg    <= '0;
            sample_index_reg <= '0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= s1_valid_reg && emit;
            if (s1_valid_reg && advance)
            begin
                run_active_reg   <= run_active_next;
                open_start_reg   <= open_start_next;
                gap_count_reg    <= gap_count_next;
                sample_index_reg <= sample_index_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_data_reg <= in_data;
        if (advance && s1_valid_reg && emit)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.run_start <= out_data_reg.run_end))
        else $error("reported run ends before it starts");

    a_index_cap: assert property (@(posedge clk) disable iff (!rst_n)
        sample_index_reg <= INDEX_CAP)
        else $error("sample index beyond cap");

    a_idle_gap: assert property (@(posedge clk) disable iff (!rst_n)
        !run_active_reg |-> (gap_count_reg == '0))
        else $error("gap count nonzero while idle");

    a_gap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_active_reg |-> (gap_count_reg <= {1'b0, gap_limit_reg}))
        else $error("open run has gap beyond close limit");

    a_start_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_active_reg |-> (open_start_reg <= sample_index_reg))
        else $error("open run starts after current index");

endmodule

@@ dv/hrd_run_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrd_run_checker
// Watches the configuration port and both word channels of the hysteresis
// run detector. It keeps its own copy of the thresholds and of the run
// tracking state, works out the run report (if any) that each accepted
// energy word causes, and compares every accepted result word with the
// oldest pending report, field by field.
// ----------------------------------------------------------------------------
module hrd_run_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  hrd_pkg::in_word_t               in_data,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  hrd_pkg::out_word_t              out_data,
    input  logic                            cfg_we,
    input  logic [hrd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hrd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              error_count,
    output int                              runs_outstanding
);
    import hrd_pkg::*;

    logic [23:0] high_lvl;
    logic [23:0] low_lvl;
    logic [15:0] gap_limit;
    logic [16:0] min_len;

    logic        tracking;
    logic [15:0] open_start;
    logic [16:0] gap_run;
    logic [15:0] next_index;

    out_word_t   expected_runs[$];

    function automatic bit long_enough(input int unsigned first, input int unsigned last);
        int unsigned span;
        span = last - first + 1;
        return span >= int'(min_len);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        out_word_t   rpt;
        out_word_t   want;
        bit          keep;
        logic [15:0] idx;
        int unsigned stop;
        if (!rst_n)
        begin
            high_lvl         = '0;
            low_lvl          = '0;
            gap_limit        = '0;
            min_len          = '0;
            tracking         = 1'b0;
            open_start       = '0;
            gap_run          = '0;
            next_index       = '0;
            error_count      = 0;
            expected_runs.delete();
            runs_outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_HIGH_THRESHOLD:    high_lvl  = cfg_data[23:0];
                    REG_LOW_THRESHOLD:     low_lvl   = cfg_data[23:0];
                    REG_GAP_CLOSE_SAMPLES: gap_limit = cfg_data[15:0];
                    REG_MIN_RUN_SAMPLES:   min_len   = cfg_data[16:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                idx  = next_index;
                keep = 1'b0;
                rpt  = '0;
                if (!tracking)
                begin
                    if (in_data.energy_sample >= high_lvl)
                    begin
                        tracking   = 1'b1;
                        open_start = idx;
                        gap_run    = '0;
                    end
                end
                else if (in_data.energy_sample >= low_lvl)
                begin
                    gap_run = '0;
                end
                else
                begin
                    gap_run = gap_run + 17'd1;
                    if (gap_run > {1'b0, gap_limit})
                    begin
                        // a gap that reaches back past the start pins the end there
                        if (int'(idx) < int'(gap_run)
                            || int'(idx) - int'(gap_run) < int'(open_start))
                            stop = open_start;
                        else
                            stop = int'(idx) - int'(gap_run);
                        keep              = long_enough(open_start, stop);
                        rpt.run_start     = open_start;
                        rpt.run_end       = stop[15:0];
                        rpt.closed_by_end = 1'b0;
                        tracking          = 1'b0;
                        gap_run           = '0;
                    end
                end

                if (in_data.last_sample)
                begin
                    if (tracking)
                    begin
                        keep              = long_enough(open_start, idx);
                        rpt.run_start     = open_start;
                        rpt.run_end       = idx;
                        rpt.closed_by_end = 1'b1;
                    end
                    tracking   = 1'b0;
                    open_start = '0;
                    gap_run    = '0;
                    next_index = '0;
                end
                else if (next_index < INDEX_CAP)
                begin
                    next_index = next_index + 16'd1;
                end

                if (keep)
                    expected_runs.insert(expected_runs.size(), rpt);
            end

            if (out_valid && out_ready)
            begin
                if (expected_runs.size() == 0)
                begin
                    $error("run report with none expected: start %0d end %0d by_end %0d",
                           out_data.run_start, out_data.run_end, out_data.closed_by_end);
                    error_count++;
                end
                else
                begin
                    want = expected_runs.pop_front();
                    if (out_data.run_start !== want.run_start)
                    begin
                        $error("run_start: expected %0d, actual %0d",
                               want.run_start, out_data.run_start);
                        error_count++;
                    end
                    if (out_data.run_end !== want.run_end)
                    begin
                        $error("run_end: expected %0d, actual %0d",
                               want.run_end, out_data.run_end);
                        error_count++;
                    end
                    if (out_data.closed_by_end !== want.closed_by_end)
                    begin
                        $error("closed_by_end: expected %0d, actual %0d",
                               want.closed_by_end, out_data.closed_by_end);
                        error_count++;
                    end
                end
            end

            runs_outstanding = expected_runs.size();
        end
    end

endmodule

@@ dv/tb_hysteresis_run_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hysteresis_run_detector
// Drives energy word streams and threshold settings into the run detector,
// with a run checker beside it. A short directed part hits the thresholds
// exactly, runs opened on the last word, reversed thresholds and length
// filtering; then random streams of run-shaped segments follow under three
// idling patterns.
// ----------------------------------------------------------------------------
module tb_hysteresis_run_detector;
    import hrd_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_word_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_word_t              out_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int pending_runs;
    int sender_idle_pct;
    int receiver_idle_pct;
    int words_sent;
    int cycle_count;

    logic [23:0] cur_high;
    logic [23:0] cur_low;
    int          cur_gap;

    hysteresis_run_detector uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hrd_run_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_data          (in_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_data         (out_data),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .error_count      (fail_count),
        .runs_outstanding (pending_runs)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);

    task automatic send_word(input logic [23:0] energy, input logic last);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid              <= 1'b1;
        in_data.energy_sample <= energy;
        in_data.last_sample   <= last;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        @(negedge clk);
    endtask

    // hold the sender until every pending run report has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_runs != 0)
            @(negedge clk);
    endtask

    task automatic load_thresholds(input logic [23:0] high, input logic [23:0] low,
                                   input logic [15:0] gap, input logic [16:0] min_run);
        drain_results();
        repeat (4) @(negedge clk);
        cur_high = high;
        cur_low  = low;
        cur_gap  = gap;
        cfg_we    <= 1'b1;
        cfg_index <= REG_HIGH_THRESHOLD;
        cfg_data  <= high;
        @(negedge clk);
        cfg_index <= REG_LOW_THRESHOLD;
        cfg_data  <= low;
        @(negedge clk);
        cfg_index <= REG_GAP_CLOSE_SAMPLES;
        cfg_data  <= CFG_DATA_W'(gap);
        @(negedge clk);
        cfg_index <= REG_MIN_RUN_SAMPLES;
        cfg_data  <= CFG_DATA_W'(min_run);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // 0: at or above high, 1: at or above low, 2: below low
    function automatic logic [23:0] pick_energy(input int kind);
        if ($urandom_range(0, 99) < 12)
            return 24'($urandom);
        case (kind)
            0:
            begin
                if ($urandom_range(0, 4) == 0)
                    return cur_high;
                return 24'($urandom_range(24'hFFFFFF, cur_high));
            end
            1:
            begin
                if ($urandom_range(0, 4) == 0)
                    return cur_low;
                return 24'($urandom_range(24'hFFFFFF, cur_low));
            end
            default:
            begin
                if (cur_low == 0)
                    return 24'd0;
                if ($urandom_range(0, 4) == 0)
                    return cur_low - 24'd1;
                return 24'($urandom_range(cur_low - 1, 0));
            end
        endcase
    endfunction

    task automatic random_stream();
        int remaining;
        int seg_len;
        int kind;
        remaining = $urandom_range(1, 40);
        kind      = ($urandom_range(0, 3) == 0) ? 2 : 0;
        while (remaining > 0)
        begin
            seg_len = $urandom_range(1, (cur_gap > 5) ? 8 : cur_gap + 3);
            repeat (seg_len)
            begin
                if (remaining > 0)
                begin
                    send_word(pick_energy(kind), remaining == 1);
                    remaining--;
                end
            end
            kind = $urandom_range(0, 2);
        end
    endtask

    task automatic random_phase(input int snd_pct, input int rcv_pct);
        int          phase_goal;
        int          setting_goal;
        logic [23:0] low;
        logic [23:0] high;
        logic [15:0] gap;
        logic [16:0] min_run;
        sender_idle_pct   = snd_pct;
        receiver_idle_pct = rcv_pct;
        phase_goal = words_sent + 140;
        while (words_sent < phase_goal)
        begin
            low = 24'($urandom);
            if ($urandom_range(0, 9) == 0)
                high = 24'($urandom_range(low, 0));
            else
                high = 24'($urandom_range(24'hFFFFFF, low));
            gap     = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 5));
            min_run = ($urandom_range(0, 9) == 0) ? 17'd65536 : 17'($urandom_range(0, 6));
            load_thresholds(high, low, gap, min_run);
            setting_goal = words_sent + 50;
            while (words_sent < setting_goal && words_sent < phase_goal)
            begin
                random_stream();
                if ($urandom_range(0, 7) == 0)
                    drain_results();
            end
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        in_data           = '0;
        cfg_we            = 1'b0;
        cfg_index         = REG_HIGH_THRESHOLD;
        cfg_data          = '0;
        words_sent        = 0;
        cycle_count       = 0;
        sender_idle_pct   = 24;
        receiver_idle_pct = 87;
        cur_high          = '0;
        cur_low           = '0;
        cur_gap           = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // exact thresholds, gap close, reopen, close by end
        load_thresholds(24'd1000, 24'd500, 16'd2, 17'd0);
        send_word(24'd0, 1'b0);
        send_word(24'd1000, 1'b0);
        send_word(24'd500, 1'b0);
        send_word(24'd499, 1'b0);
        send_word(24'd499, 1'b0);
        send_word(24'd499, 1'b0);
        send_word(24'hFFFFFF, 1'b0);
        send_word(24'd0, 1'b1);
        // run opened on the last word, then a stream with no run
        send_word(24'd2000, 1'b1);
        send_word(24'd0, 1'b1);

        // low above high, one-word run filtered by length
        load_thresholds(24'd100, 24'hFFFFFF, 16'd0, 17'd2);
        send_word(24'd100, 1'b0);
        send_word(24'd50, 1'b0);
        send_word(24'd200, 1'b0);
        send_word(24'hFFFFFF, 1'b0);
        send_word(24'd0, 1'b0);
        send_word(24'd0, 1'b1);

        // all zero: every word opens or holds a run
        load_thresholds(24'd0, 24'd0, 16'd0, 17'd0);
        send_word(24'd0, 1'b0);
        send_word(24'd7, 1'b0);
        send_word(24'd0, 1'b1);

        random_phase(24, 87);
        random_phase(87, 24);
        random_phase(0, 0);

        drain_results();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
